// ===== hdl/accel_step_detector_macros.svh =====
// Assertion macros for the step detector.
// Define NO_ASSERTIONS to compile them away.
`ifndef ACCEL_STEP_DETECTOR_MACROS_SVH
`define ACCEL_STEP_DETECTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define ASD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked on every clock edge at which a condition holds.
`define ASD_ASSERT_IF(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
`else
`define ASD_ASSERT(lbl, clk, rst_n, prop, msg)
`define ASD_ASSERT_IF(lbl, clk, rst_n, cond, prop, msg)
`endif
`endif

// ===== hdl/asd_pkg.sv =====
`timescale 1ns / 1ps

package asd_pkg;

  // Default axis width used by the sign extension of the inputs.
  localparam int unsigned AXIS_WIDTH_DEF = 16;

  // Widths of the configuration port.
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 20;

  // Item opcodes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HP_ALPHA       = 4'd0,
    REG_LP_BETA        = 4'd1,
    REG_THRESHOLD_HIGH = 4'd2,
    REG_THRESHOLD_LOW  = 4'd3,
    REG_MIN_HALF_TICKS = 4'd4,
    REG_MAX_HALF_TICKS = 4'd5,
    REG_MIN_SWING      = 4'd6,
    REG_GUARD_COUNT    = 4'd7
  } cfg_reg_e;

  // Configuration reset values.
  localparam logic        [15:0] HP_ALPHA_RST       = 16'd62259;
  localparam logic        [15:0] LP_BETA_RST        = 16'd13107;
  localparam logic signed [19:0] THRESHOLD_HIGH_RST = 20'sd614;
  localparam logic signed [19:0] THRESHOLD_LOW_RST  = -20'sd614;
  localparam logic        [9:0]  MIN_HALF_TICKS_RST = 10'd5;
  localparam logic        [9:0]  MAX_HALF_TICKS_RST = 10'd50;
  localparam logic        [19:0] MIN_SWING_RST      = 20'd1229;
  localparam logic        [7:0]  GUARD_COUNT_RST    = 8'd4;

  // Magnitude after reset: 1 g in Q4.12.
  localparam logic [15:0] MAGNITUDE_RST = 16'd4096;

  // Detector phases.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PEAK   = 2'd1,
    PH_VALLEY = 2'd2
  } phase_e;

  // Input transaction.
  typedef struct packed {
    logic               opcode;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  // Output transaction.
  typedef struct packed {
    logic        [31:0] step_count;
    logic               step_seen;
    logic        [1:0]  detector_phase;
    logic signed [19:0] smoothed;
  } out_item_t;

endpackage

// ===== hdl/accel_step_detector.sv =====
// Peak/valley step detector for a three-axis accelerometer. The input is stalled from the
// acceptance of a sample transaction until its result is handed to the output register, so a
// new sample is not taken before the last one is through; one shared 21x17 multiplier is used
// for the three squares and both filters, and the 16-step integer square root runs one result
// bit per cycle. A clear transaction goes from acceptance straight to the hand-over state. A finished
// result waits in the output register while the next transaction is accepted. Configuration
// writes are always ready and must be issued only while no transaction is in flight.
`timescale 1ns / 1ps
`include "accel_step_detector_macros.svh"

module accel_step_detector #(
  parameter int unsigned AXIS_WIDTH = asd_pkg::AXIS_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  asd_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output asd_pkg::out_item_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [asd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [asd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SUM,
    ST_SQRT,
    ST_HP_DIFF,
    ST_HP_MUL,
    ST_HP_RND,
    ST_LP_DIFF,
    ST_LP_MUL,
    ST_LP_RND,
    ST_DETECT,
    ST_DONE
  } state_e;

  // Round half up, drop 16 fraction bits and saturate to signed 20 bits.
  function automatic logic signed [19:0] round_sat(input logic signed [39:0] x);
    logic signed [39:0] y;
    logic signed [23:0] q;
    y = x + 40'sd32768;
    q = y[39:16];
    if (q > 24'sd524287) begin
      return 20'sd524287;
    end else if (q < -24'sd524288) begin
      return -20'sd524288;
    end else begin
      return q[19:0];
    end
  endfunction

  // Control, configuration and filter state.
  state_e             state_q, state_d;
  logic        [3:0]  cnt_q, cnt_d;
  logic        [15:0] hp_alpha_q, hp_alpha_d;
  logic        [15:0] lp_beta_q, lp_beta_d;
  logic signed [19:0] th_high_q, th_high_d;
  logic signed [19:0] th_low_q, th_low_d;
  logic        [9:0]  min_half_q, min_half_d;
  logic        [9:0]  max_half_q, max_half_d;
  logic        [19:0] min_swing_q, min_swing_d;
  logic        [7:0]  guard_cnt_q, guard_cnt_d;
  logic        [15:0] last_mag_q, last_mag_d;
  logic signed [19:0] last_hp_q, last_hp_d;
  logic signed [19:0] last_lp_q, last_lp_d;
  asd_pkg::phase_e    phase_q, phase_d;
  logic signed [19:0] ext_q, ext_d;
  logic        [31:0] tick_q, tick_d;
  logic        [31:0] event_q, event_d;
  logic        [7:0]  guard_left_q, guard_left_d;
  logic        [31:0] step_q, step_d;
  asd_pkg::out_item_t res_q, res_d;
  logic               out_valid_q, out_valid_d;
  asd_pkg::out_item_t out_q, out_d;

  // Datapath registers.
  logic signed [15:0] ax_q, ax_d, ay_q, ay_d, az_q, az_d;
  logic signed [37:0] prod_q, prod_d;
  logic        [31:0] acc_q, acc_d;
  logic        [31:0] root_q, root_d;
  logic        [31:0] bit_q, bit_d;
  logic signed [20:0] diff_q, diff_d;

  // Shared multiplier.
  logic signed [20:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [37:0] mul_p;

  // Detector helpers.
  logic        [31:0] trial;
  logic signed [19:0] hp_val, lp_val, ext_n;
  logic        [31:0] since;
  logic               since_ge_min, since_gt_max;
  logic signed [20:0] swing;
  logic               seen;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_q)
      ST_SQ_X: begin
        mul_a = 21'($signed(ax_q[AXIS_WIDTH-1:0]));
        mul_b = 17'($signed(ax_q[AXIS_WIDTH-1:0]));
      end
      ST_SQ_Y: begin
        mul_a = 21'($signed(ay_q[AXIS_WIDTH-1:0]));
        mul_b = 17'($signed(ay_q[AXIS_WIDTH-1:0]));
      end
      ST_SQ_Z: begin
        mul_a = 21'($signed(az_q[AXIS_WIDTH-1:0]));
        mul_b = 17'($signed(az_q[AXIS_WIDTH-1:0]));
      end
      ST_HP_MUL: begin
        mul_a = diff_q;
        mul_b = $signed({1'b0, hp_alpha_q});
      end
      ST_LP_MUL: begin
        mul_a = diff_q;
        mul_b = $signed({1'b0, lp_beta_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 38'(mul_a) * 38'(mul_b);

  // Square root trial value and filter rounding.
  assign trial  = root_q + bit_q;
  assign hp_val = round_sat(40'(prod_q));
  assign lp_val = round_sat(40'(prod_q) + (40'(last_lp_q) <<< 16));

  // Detector comparisons: ticks since the last event, and the swing of the smoothed value in last_lp_q.
  assign since        = tick_q - event_q;
  assign since_ge_min = (since >= {22'd0, min_half_q});
  assign since_gt_max = (since > {22'd0, max_half_q});

  always_comb begin
    ext_n = ext_q;
    if (phase_q == asd_pkg::PH_PEAK) begin
      if (last_lp_q > ext_q) ext_n = last_lp_q;
    end else if (phase_q != asd_pkg::PH_IDLE) begin
      if (last_lp_q < ext_q) ext_n = last_lp_q;
    end
  end

  assign swing = {ext_n[19], ext_n} - {last_lp_q[19], last_lp_q};

  // Next-state logic for the sequencer and all state.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    hp_alpha_d   = hp_alpha_q;
    lp_beta_d    = lp_beta_q;
    th_high_d    = th_high_q;
    th_low_d     = th_low_q;
    min_half_d   = min_half_q;
    max_half_d   = max_half_q;
    min_swing_d  = min_swing_q;
    guard_cnt_d  = guard_cnt_q;
    last_mag_d   = last_mag_q;
    last_hp_d    = last_hp_q;
    last_lp_d    = last_lp_q;
    phase_d      = phase_q;
    ext_d        = ext_q;
    tick_d       = tick_q;
    event_d      = event_q;
    guard_left_d = guard_left_q;
    step_d       = step_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    ax_d         = ax_q;
    ay_d         = ay_q;
    az_d         = az_q;
    prod_d       = prod_q;
    acc_d        = acc_q;
    root_d       = root_q;
    bit_d        = bit_q;
    diff_d       = diff_q;
    seen         = 1'b0;

    // Configuration writes; indexes beyond the list are dropped.
    if (cfg_valid_i) begin
      case (cfg_index_i)
        asd_pkg::REG_HP_ALPHA:       hp_alpha_d  = cfg_data_i[15:0];
        asd_pkg::REG_LP_BETA:        lp_beta_d   = cfg_data_i[15:0];
        asd_pkg::REG_THRESHOLD_HIGH: th_high_d   = $signed(cfg_data_i);
        asd_pkg::REG_THRESHOLD_LOW:  th_low_d    = $signed(cfg_data_i);
        asd_pkg::REG_MIN_HALF_TICKS: min_half_d  = cfg_data_i[9:0];
        asd_pkg::REG_MAX_HALF_TICKS: max_half_d  = cfg_data_i[9:0];
        asd_pkg::REG_MIN_SWING:      min_swing_d = cfg_data_i;
        asd_pkg::REG_GUARD_COUNT:    guard_cnt_d = cfg_data_i[7:0];
        default: ;
      endcase
    end

    // The output register empties when its transaction is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ax_d = in_data_i.accel_x;
          ay_d = in_data_i.accel_y;
          az_d = in_data_i.accel_z;
          if (in_data_i.opcode == asd_pkg::OP_CLEAR) begin
            // Clear restarts counting and leaves the filters alone.
            step_d       = '0;
            guard_left_d = guard_cnt_q;
            phase_d      = asd_pkg::PH_IDLE;
            event_d      = tick_q;
            res_d        = '0;
            state_d      = ST_DONE;
          end else begin
            tick_d  = tick_q + 32'd1;
            state_d = ST_SQ_X;
          end
        end
      end
      ST_SQ_X: begin
        prod_d  = mul_p;
        state_d = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        acc_d   = prod_q[31:0];
        prod_d  = mul_p;
        state_d = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        acc_d   = acc_q + prod_q[31:0];
        prod_d  = mul_p;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        acc_d   = acc_q + prod_q[31:0];
        root_d  = '0;
        bit_d   = 32'h4000_0000;
        cnt_d   = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        // One result bit per cycle of the digit-by-digit square root.
        if (acc_q >= trial) begin
          acc_d  = acc_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = ST_HP_DIFF;
        end
      end
      ST_HP_DIFF: begin
        diff_d  = {last_hp_q[19], last_hp_q} + $signed({5'd0, root_q[15:0]})
                - $signed({5'd0, last_mag_q});
        state_d = ST_HP_MUL;
      end
      ST_HP_MUL: begin
        prod_d  = mul_p;
        state_d = ST_HP_RND;
      end
      ST_HP_RND: begin
        last_hp_d  = hp_val;
        last_mag_d = root_q[15:0];
        state_d    = ST_LP_DIFF;
      end
      ST_LP_DIFF: begin
        // beta*h + (1-beta)*l is formed as l + beta*(h - l).
        diff_d  = {last_hp_q[19], last_hp_q} - {last_lp_q[19], last_lp_q};
        state_d = ST_LP_MUL;
      end
      ST_LP_MUL: begin
        prod_d  = mul_p;
        state_d = ST_LP_RND;
      end
      ST_LP_RND: begin
        last_lp_d = lp_val;
        state_d   = ST_DETECT;
      end
      ST_DETECT: begin
        ext_d = ext_n;
        case (phase_q)
          asd_pkg::PH_IDLE: begin
            if (last_lp_q > th_high_q) begin
              ext_d   = last_lp_q;
              event_d = tick_q;
              phase_d = asd_pkg::PH_PEAK;
            end
          end
          asd_pkg::PH_PEAK: begin
            if (last_lp_q < th_low_q && since_ge_min) begin
              if (!since_gt_max && swing >= $signed({1'b0, min_swing_q})) begin
                ext_d   = last_lp_q;
                event_d = tick_q;
                phase_d = asd_pkg::PH_VALLEY;
              end else begin
                phase_d = asd_pkg::PH_IDLE;
              end
            end else if (since_gt_max) begin
              phase_d = asd_pkg::PH_IDLE;
            end
          end
          default: begin
            // After a valley, a new peak completes one full step cycle.
            if (last_lp_q > th_high_q && since_ge_min) begin
              if (!since_gt_max) begin
                if (guard_left_q != 8'd0) begin
                  guard_left_d = guard_left_q - 8'd1;
                end else begin
                  step_d = step_q + 32'd1;
                  seen   = 1'b1;
                end
                ext_d   = last_lp_q;
                event_d = tick_q;
                phase_d = asd_pkg::PH_PEAK;
              end else begin
                phase_d = asd_pkg::PH_IDLE;
              end
            end else if (since_gt_max) begin
              phase_d = asd_pkg::PH_IDLE;
            end
          end
        endcase
        res_d.step_count     = step_d;
        res_d.step_seen      = seen;
        res_d.detector_phase = phase_d;
        res_d.smoothed       = last_lp_q;
        state_d              = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer, configuration, filter and detector state, output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      hp_alpha_q   <= asd_pkg::HP_ALPHA_RST;
      lp_beta_q    <= asd_pkg::LP_BETA_RST;
      th_high_q    <= asd_pkg::THRESHOLD_HIGH_RST;
      th_low_q     <= asd_pkg::THRESHOLD_LOW_RST;
      min_half_q   <= asd_pkg::MIN_HALF_TICKS_RST;
      max_half_q   <= asd_pkg::MAX_HALF_TICKS_RST;
      min_swing_q  <= asd_pkg::MIN_SWING_RST;
      guard_cnt_q  <= asd_pkg::GUARD_COUNT_RST;
      last_mag_q   <= asd_pkg::MAGNITUDE_RST;
      last_hp_q    <= '0;
      last_lp_q    <= '0;
      phase_q      <= asd_pkg::PH_IDLE;
      ext_q        <= '0;
      tick_q       <= '0;
      event_q      <= '0;
      guard_left_q <= asd_pkg::GUARD_COUNT_RST;
      step_q       <= '0;
      res_q        <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      hp_alpha_q   <= hp_alpha_d;
      lp_beta_q    <= lp_beta_d;
      th_high_q    <= th_high_d;
      th_low_q     <= th_low_d;
      min_half_q   <= min_half_d;
      max_half_q   <= max_half_d;
      min_swing_q  <= min_swing_d;
      guard_cnt_q  <= guard_cnt_d;
      last_mag_q   <= last_mag_d;
      last_hp_q    <= last_hp_d;
      last_lp_q    <= last_lp_d;
      phase_q      <= phase_d;
      ext_q        <= ext_d;
      tick_q       <= tick_d;
      event_q      <= event_d;
      guard_left_q <= guard_left_d;
      step_q       <= step_d;
      res_q        <= res_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  // Working registers of the arithmetic datapath.
  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    az_q   <= az_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    diff_q <= diff_d;
  end

  // Checks on the sequencer and the detector.
  `ASD_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "block not busy after an accepted transaction")
  `ASD_ASSERT_IF(a_seen_is_peak, clk_i, rst_ni, out_valid_o && out_data_o.step_seen, out_data_o.detector_phase == asd_pkg::PH_PEAK, "counted step without entering peak phase")
  `ASD_ASSERT_IF(a_seen_no_guard, clk_i, rst_ni, state_q == ST_DONE && res_q.step_seen, guard_left_q == 8'd0, "step counted while guard credits remain")
  `ASD_ASSERT_IF(a_root_fits, clk_i, rst_ni, state_q == ST_HP_DIFF, root_q[31:16] == 16'd0, "square root exceeds 16 bits")

endmodule
